FILE: design/fclb_pkg.sv
// ----------------------------------------------------------------------------
// fclb_pkg
// Shared types, constants and the backend hash for the flow cache balancer.
// ----------------------------------------------------------------------------
package fclb_pkg;

    localparam int TABLE_ENTRIES_DEF = 1024;
    localparam int BACKEND_COUNT_DEF = 8;

    localparam int KEY_W  = 32;
    localparam int TS_W   = 63;
    localparam int RIDX_W = 10;
    localparam int BE_W   = 3;

    // Width of the hash product that matters for a modulus of at most 64
    localparam int HASH_W = 6;
    localparam logic [31:0] HASH_MULT = 32'h9E37_79B1;

    typedef enum logic {
        MODE_PACKET = 1'b0,
        MODE_READ   = 1'b1
    } mode_t;

    typedef struct packed {
        mode_t             mode;
        logic [KEY_W-1:0]  flow_key;
        logic [TS_W-1:0]   timestamp;
        logic [RIDX_W-1:0] entry_index;
    } in_item_t;

    typedef struct packed {
        logic              hit;
        logic [KEY_W-1:0]  key_out;
        logic [BE_W-1:0]   backend;
        logic [TS_W-1:0]   seen_time;
        logic              entry_valid;
    } out_item_t;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [BE_W-1:0]  backend;
        logic [TS_W-1:0]  seen;
    } entry_t;

    // Low bits of key * HASH_MULT: only the low HASH_W bits of each factor
    // reach a power-of-two modulus of at most 64.
    function automatic logic [BE_W-1:0] pick_backend(
        input logic [KEY_W-1:0]  key,
        input logic [HASH_W-1:0] mask
    );
        logic [HASH_W-1:0] prod;
        prod = key[HASH_W-1:0] * HASH_MULT[HASH_W-1:0];
        return BE_W'(prod & mask);
    endfunction

endpackage

FILE: design/fclb_table.sv
// ----------------------------------------------------------------------------
// fclb_table
// Flow table memory: one read and one write port, registered read, a
// forward path for a write to the entry being read, and a clearing sweep.
// ----------------------------------------------------------------------------
module fclb_table #(
    parameter int TABLE_ENTRIES = fclb_pkg::TABLE_ENTRIES_DEF,
    parameter int IDX_W         = $clog2(TABLE_ENTRIES)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 rd_en,
    input  logic [IDX_W-1:0]     rd_idx,
    input  logic                 wr_en,
    input  logic [IDX_W-1:0]     wr_idx,
    input  fclb_pkg::entry_t     wr_entry,
    output fclb_pkg::entry_t     rd_entry,
    output logic                 ready
);

    fclb_pkg::entry_t table_mem [TABLE_ENTRIES];

    fclb_pkg::entry_t rd_data_reg;
    fclb_pkg::entry_t fwd_data_reg;
    logic             fwd_sel_reg;
    logic             clearing_reg;
    logic [IDX_W-1:0] clr_idx_reg;

    always_ff @(posedge aclk) begin
        if (clearing_reg) begin
            table_mem[clr_idx_reg] <= '0;
        end else if (wr_en) begin
            table_mem[wr_idx] <= wr_entry;
        end
    end

    // Read returns old data on a same-cycle write; capture the write instead
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg  <= table_mem[rd_idx];
            fwd_data_reg <= wr_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_sel_reg <= 1'b0;
        end else if (rd_en) begin
            fwd_sel_reg <= wr_en && !clearing_reg && (wr_idx == rd_idx);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg <= 1'b1;
            clr_idx_reg  <= '0;
        end else if (clearing_reg) begin
            clr_idx_reg <= clr_idx_reg + 1'b1;
            if (clr_idx_reg == IDX_W'(TABLE_ENTRIES - 1)) begin
                clearing_reg <= 1'b0;
            end
        end
    end

    assign rd_entry = fwd_sel_reg ? fwd_data_reg : rd_data_reg;
    assign ready    = !clearing_reg;

endmodule

FILE: design/fclb_update.sv
// ----------------------------------------------------------------------------
// fclb_update
// Lookup and learn: hit check, backend choice, new entry and result item.
// ----------------------------------------------------------------------------
module fclb_update #(
    parameter int BACKEND_COUNT = fclb_pkg::BACKEND_COUNT_DEF
) (
    input  fclb_pkg::in_item_t  item,
    input  fclb_pkg::entry_t    entry,
    output fclb_pkg::entry_t    wr_entry,
    output fclb_pkg::out_item_t result
);

    localparam logic [fclb_pkg::HASH_W-1:0] BACKEND_MASK =
        fclb_pkg::HASH_W'(BACKEND_COUNT - 1);

    logic                       hit;
    logic [fclb_pkg::BE_W-1:0]  backend;

    assign hit     = entry.valid && (entry.key == item.flow_key);
    assign backend = hit ? entry.backend
                         : fclb_pkg::pick_backend(item.flow_key, BACKEND_MASK);

    always_comb begin
        wr_entry.valid   = 1'b1;
        wr_entry.key     = item.flow_key;
        wr_entry.backend = backend;
        wr_entry.seen    = item.timestamp;
    end

    always_comb begin
        result = '0;
        unique case (item.mode)
            fclb_pkg::MODE_PACKET: begin
                result.hit         = hit;
                result.key_out     = item.flow_key;
                result.backend     = backend;
                result.seen_time   = item.timestamp;
                result.entry_valid = 1'b1;
            end
            fclb_pkg::MODE_READ: begin
                // hide contents of an entry that was never learned
                if (entry.valid) begin
                    result.key_out     = entry.key;
                    result.backend     = entry.backend;
                    result.seen_time   = entry.seen;
                    result.entry_valid = 1'b1;
                end
            end
            default: begin
                result = '0;
            end
        endcase
    end

endmodule

FILE: design/flow_cache_load_balancer.sv
// ----------------------------------------------------------------------------
// flow_cache_load_balancer
// Direct-mapped learning flow table that pins each flow to a backend.
// ----------------------------------------------------------------------------
// Usage:
//   Input items arrive on s_valid/s_ready/s_item. In packet mode the low key
//   bits select a table entry; a valid entry with an equal key is a hit, any
//   other case learns the key and hashes it to a backend. Every packet stamps
//   the entry's last-seen time. In read mode the entry at entry_index is
//   returned, zeros if it was never learned.
//   Result items leave on m_valid/m_ready/m_item, one per input item, in order.
//   Items pass the lookup stage and output registers. Throughput: one item
//   per cycle unless m_ready stalls, set by the single read-modify-write
//   pass through the table memory; a write to the entry read in the same
//   cycle is forwarded, so equal keys may follow back to back.
//   Reset: a clearing sweep writes every entry invalid with s_ready low,
//   then items are taken.
//   Stall: while m_ready is low the output register holds its item, one more
//   item waits in the lookup stage and s_ready drops.
//   BACKEND_COUNT must be a power of two.
// ----------------------------------------------------------------------------
module flow_cache_load_balancer #(
    parameter int TABLE_ENTRIES = fclb_pkg::TABLE_ENTRIES_DEF,
    parameter int BACKEND_COUNT = fclb_pkg::BACKEND_COUNT_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  fclb_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output fclb_pkg::out_item_t m_item
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);

    logic                s_accept;
    logic                out_free;
    logic                advance;
    logic                tbl_ready;

    logic [IDX_W-1:0]    rd_idx;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_idx;
    fclb_pkg::entry_t    wr_entry;
    fclb_pkg::entry_t    rd_entry;
    fclb_pkg::out_item_t upd_result;

    // lookup stage: item whose entry read is under way
    logic                p1_valid_reg;
    fclb_pkg::in_item_t  p1_item_reg;

    // output register
    logic                m_valid_reg;
    fclb_pkg::out_item_t m_item_reg;

    assign out_free = !m_valid_reg || m_ready;
    assign advance  = p1_valid_reg && out_free;
    assign s_ready  = tbl_ready && (!p1_valid_reg || out_free);
    assign s_accept = s_valid && s_ready;

    // read index: key bits for a packet, wrapped entry_index for a read
    assign rd_idx = (s_item.mode == fclb_pkg::MODE_READ) ? IDX_W'(s_item.entry_index)
                                                         : s_item.flow_key[IDX_W-1:0];

    // write back only packets, once, as the item leaves the lookup stage
    assign wr_en  = advance && (p1_item_reg.mode == fclb_pkg::MODE_PACKET);
    assign wr_idx = p1_item_reg.flow_key[IDX_W-1:0];

    fclb_table #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .IDX_W         (IDX_W)
    ) u_table (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (s_accept),
        .rd_idx   (rd_idx),
        .wr_en    (wr_en),
        .wr_idx   (wr_idx),
        .wr_entry (wr_entry),
        .rd_entry (rd_entry),
        .ready    (tbl_ready)
    );

    fclb_update #(
        .BACKEND_COUNT (BACKEND_COUNT)
    ) u_update (
        .item     (p1_item_reg),
        .entry    (rd_entry),
        .wr_entry (wr_entry),
        .result   (upd_result)
    );

    // Advance the lookup stage on accept, drop it once its result moves out
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (s_accept) begin
            p1_valid_reg <= 1'b1;
        end else if (advance) begin
            p1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            p1_item_reg <= s_item;
        end
    end

    // Hold the result until the receiver takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_item_reg <= upd_result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // A hit always reports a valid entry
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_item_reg.hit |-> m_item_reg.entry_valid)
        else $error("hit reported on an invalid entry");

    // An invalid entry never exposes stored contents
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_item_reg.entry_valid |->
            (m_item_reg.key_out == '0) && (m_item_reg.backend == '0) &&
            (m_item_reg.seen_time == '0))
        else $error("invalid entry returned nonzero contents");

    // Back-to-back packets with the same key: the second one must hit
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && (s_item.mode == fclb_pkg::MODE_PACKET)) ##1
        (s_accept && (s_item.mode == fclb_pkg::MODE_PACKET) &&
         (s_item.flow_key == $past(s_item.flow_key)))
        |=> upd_result.hit)
        else $error("forwarding missed a same-entry update");

    // No item is taken during the clearing sweep
    assert property (@(posedge aclk) disable iff (!aresetn)
        !tbl_ready |=> !p1_valid_reg)
        else $error("item entered during table clear");

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the direct-mapped flow cache load balancer.
// A short table of directed items covers empty reads, the key and timestamp
// extremes, learning, hits, evictions by colliding keys and entry reads.
// Random traffic follows, built mostly from a pool of live flows so that
// hits, back-to-back repeats, collisions and reads of learned entries dominate.
// Every accepted item is run through a local copy of the flow table and each
// result is compared field by field against the oldest expected result.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int SLOTS       = fclb_pkg::TABLE_ENTRIES_DEF;
    localparam int RAND_ITEMS  = 450;
    localparam int POOL_MAX    = 48;
    localparam int REPORT_MAX  = 10;
    localparam int TAIL_CYCLES = 8;
    // The reset sweep plus ~470 items, each allowed a long sender gap and a long
    // receiver stall, sets the run length; the timeout takes it many times.
    localparam longint TIMEOUT_NS = 64'd5_000_000;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    fclb_pkg::in_item_t  s_item;
    logic                m_valid;
    logic                m_ready;
    fclb_pkg::out_item_t m_item;

    flow_cache_load_balancer DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    // ------------------------------------------------------------------
    // Local flow table, mirrored from the block's behavior
    // ------------------------------------------------------------------
    bit                          tbl_valid   [SLOTS];
    bit [fclb_pkg::KEY_W-1:0]    tbl_key     [SLOTS];
    bit [fclb_pkg::BE_W-1:0]     tbl_backend [SLOTS];
    bit [fclb_pkg::TS_W-1:0]     tbl_seen    [SLOTS];

    fclb_pkg::out_item_t pending_results[$];
    int                  fail_count;

    // Directed table row: the item, and a typed-in result where one is given
    typedef struct {
        fclb_pkg::in_item_t  stim;
        bit                  typed;
        fclb_pkg::out_item_t want;
    } dir_row_t;

    dir_row_t dir_rows[$];

    // Apply one item to the local table and return the result it causes.
    function automatic fclb_pkg::out_item_t flow_table_predict(
        input fclb_pkg::in_item_t it
    );
        fclb_pkg::out_item_t          res;
        bit [fclb_pkg::RIDX_W-1:0]    slot;
        bit [63:0]                    prod;
        bit                           hit;
        res = '0;
        if (it.mode == fclb_pkg::MODE_PACKET) begin
            slot = it.flow_key[fclb_pkg::RIDX_W-1:0];
            hit  = tbl_valid[slot] && (tbl_key[slot] == it.flow_key);
            if (!hit) begin
                // Learn the flow; backend is the hash product mod 8
                prod              = 64'(it.flow_key) * 64'd2654435761;
                tbl_valid[slot]   = 1'b1;
                tbl_key[slot]     = it.flow_key;
                tbl_backend[slot] = prod[fclb_pkg::BE_W-1:0];
            end
            tbl_seen[slot]  = it.timestamp;
            res.hit         = hit;
            res.key_out     = it.flow_key;
            res.backend     = tbl_backend[slot];
            res.seen_time   = it.timestamp;
            res.entry_valid = 1'b1;
        end else begin
            slot = it.entry_index;
            // Invalid entries read back as all zero
            if (tbl_valid[slot]) begin
                res.key_out     = tbl_key[slot];
                res.backend     = tbl_backend[slot];
                res.seen_time   = tbl_seen[slot];
                res.entry_valid = 1'b1;
            end
        end
        return res;
    endfunction

    function automatic fclb_pkg::out_item_t result_of(
        input bit                       hit,
        input bit [fclb_pkg::KEY_W-1:0] key,
        input bit [fclb_pkg::BE_W-1:0]  be,
        input bit [fclb_pkg::TS_W-1:0]  seen,
        input bit                       ev
    );
        fclb_pkg::out_item_t res;
        res.hit         = hit;
        res.key_out     = key;
        res.backend     = be;
        res.seen_time   = seen;
        res.entry_valid = ev;
        return res;
    endfunction

    task automatic add_row(input fclb_pkg::mode_t m,
                           input bit [fclb_pkg::KEY_W-1:0] key,
                           input bit [fclb_pkg::TS_W-1:0] ts,
                           input bit [fclb_pkg::RIDX_W-1:0] idx,
                           input bit typed, input fclb_pkg::out_item_t want);
        dir_row_t row;
        row.stim.mode        = m;
        row.stim.flow_key    = key;
        row.stim.timestamp   = ts;
        row.stim.entry_index = idx;
        row.typed            = typed;
        row.want             = want;
        dir_rows.insert(dir_rows.size(), row);
    endtask

    // Idle length: mostly none, often short, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Drive one item from a falling edge, hold it until the handshake, then
    // record what the table predicts for it. Returns at the next falling edge.
    task automatic send_item(input fclb_pkg::in_item_t it, input int gap,
                             input bit typed, input fclb_pkg::out_item_t want);
        fclb_pkg::out_item_t predicted;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_item  <= it;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        // Keep the local table in step even when the result is typed in
        predicted = flow_table_predict(it);
        pending_results.insert(pending_results.size(), typed ? want : predicted);
        @(negedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        aresetn = 1'b0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Timeout guard
    // ------------------------------------------------------------------
    initial begin
        #(TIMEOUT_NS);
        $display("[flow_cache_load_balancer] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver pacing: drop m_ready for random stalls, with calm stretches
    // where it stays high. At most one assignment per falling edge.
    // ------------------------------------------------------------------
    initial begin : rx_pacing
        int  left;
        int  gap;
        int  cyc;
        bit  calm;
        m_ready = 1'b0;
        left    = 0;
        cyc     = 0;
        forever begin
            @(negedge aclk);
            cyc++;
            calm = ((cyc / 1500) % 4) == 2;
            if (left > 0) begin
                left--;
            end else if (m_ready && !calm) begin
                gap = idle_len();
                if (gap > 0) begin
                    m_ready <= 1'b0;
                    left = gap - 1;
                end else begin
                    left = $urandom_range(0, 6);
                end
            end else begin
                m_ready <= 1'b1;
                left = $urandom_range(0, 10);
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checker: sample at the rising edge, compare with the oldest
    // expected result, report the first few failures in full.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : result_check
        fclb_pkg::out_item_t want;
        bit                  bad;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_MAX)
                    $display("unexpected result item: key %h backend %0d seen %h",
                             m_item.key_out, m_item.backend, m_item.seen_time);
            end else begin
                want = pending_results.pop_front();
                bad  = (m_item.hit !== want.hit) || (m_item.key_out !== want.key_out) ||
                       (m_item.backend !== want.backend) ||
                       (m_item.seen_time !== want.seen_time) ||
                       (m_item.entry_valid !== want.entry_valid);
                if (bad) begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX) begin
                        $display("mismatch (expected / actual):");
                        $display("  hit %0d / %0d  valid %0d / %0d  backend %0d / %0d",
                                 want.hit, m_item.hit, want.entry_valid,
                                 m_item.entry_valid, want.backend, m_item.backend);
                        $display("  key %h / %h  seen %h / %h", want.key_out,
                                 m_item.key_out, want.seen_time, m_item.seen_time);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        fclb_pkg::in_item_t          it;
        bit [fclb_pkg::KEY_W-1:0]    flow_pool[$];
        bit [fclb_pkg::KEY_W-1:0]    last_key;
        bit [fclb_pkg::KEY_W-1:0]    pick;
        bit [fclb_pkg::TS_W-1:0]     ts_max;
        int                          r;
        int                          gap;
        bit                          have_flow;

        s_valid    = 1'b0;
        s_item     = '0;
        fail_count = 0;
        ts_max     = '1;
        last_key   = '0;

        // Directed rows. Typed results are the ones plain from the spec:
        // empty reads, key zero and all-ones, their repeats.
        // Read entries right after reset: nothing learned, all zero
        add_row(fclb_pkg::MODE_READ,   32'h0000_0000, 63'd0, 10'd0, 1'b1,
                result_of(1'b0, '0, '0, '0, 1'b0));
        add_row(fclb_pkg::MODE_READ,   32'hFFFF_FFFF, ts_max, 10'd1023, 1'b1,
                result_of(1'b0, '0, '0, '0, 1'b0));
        // Learn key zero, then hit it again with the largest timestamp
        add_row(fclb_pkg::MODE_PACKET, 32'h0000_0000, 63'd0, 10'd1023, 1'b1,
                result_of(1'b0, '0, '0, '0, 1'b1));
        add_row(fclb_pkg::MODE_PACKET, 32'h0000_0000, ts_max, 10'd0, 1'b1,
                result_of(1'b1, '0, '0, ts_max, 1'b1));
        add_row(fclb_pkg::MODE_READ,   32'h0000_0000, 63'd0, 10'd0, 1'b1,
                result_of(1'b0, '0, '0, ts_max, 1'b1));
        // All-ones key lands in the last entry with backend 7
        add_row(fclb_pkg::MODE_PACKET, 32'hFFFF_FFFF, 63'd1, 10'd0, 1'b1,
                result_of(1'b0, 32'hFFFF_FFFF, 3'd7, 63'd1, 1'b1));
        add_row(fclb_pkg::MODE_PACKET, 32'hFFFF_FFFF, 63'd2, 10'd0, 1'b1,
                result_of(1'b1, 32'hFFFF_FFFF, 3'd7, 63'd2, 1'b1));
        // Colliding keys evict each other in the same entry
        add_row(fclb_pkg::MODE_PACKET, 32'h0000_03FF, 63'd3, 10'd5, 1'b0, '0);
        add_row(fclb_pkg::MODE_READ,   32'h1234_5678, 63'd9, 10'd1023, 1'b0, '0);
        add_row(fclb_pkg::MODE_PACKET, 32'hFFFF_FFFF, 63'd4, 10'd0, 1'b0, '0);
        add_row(fclb_pkg::MODE_PACKET, 32'h1234_5400, 63'h1234_5678_9ABC, 10'd77,
                1'b0, '0);
        add_row(fclb_pkg::MODE_READ,   32'h0000_0000, 63'd0, 10'd0, 1'b0, '0);
        add_row(fclb_pkg::MODE_PACKET, 32'h8000_0001, 63'h4000_0000_0000_0000, 10'd3,
                1'b0, '0);
        add_row(fclb_pkg::MODE_READ,   32'h0000_0000, 63'd0, 10'd1, 1'b0, '0);
        // Entry never learned still reads as zero mid-run
        add_row(fclb_pkg::MODE_READ,   32'hDEAD_BEEF, ts_max, 10'd512, 1'b1,
                result_of(1'b0, '0, '0, '0, 1'b0));
        // Alternating bit patterns on key, timestamp and index
        add_row(fclb_pkg::MODE_PACKET, 32'h5555_5555, 63'h5555_5555_5555_5555, 10'h2AA,
                1'b0, '0);
        add_row(fclb_pkg::MODE_PACKET, 32'hAAAA_AAAA, 63'h2AAA_AAAA_AAAA_AAAA, 10'h155,
                1'b0, '0);
        add_row(fclb_pkg::MODE_READ,   32'hFFFF_FFFF, ts_max, 10'h155, 1'b0, '0);
        add_row(fclb_pkg::MODE_READ,   32'h0000_0000, 63'd0,  10'h2AA, 1'b0, '0);
        add_row(fclb_pkg::MODE_PACKET, 32'h5555_5555, 63'd0,  10'h3FF, 1'b0, '0);

        // Hold off until reset is released; the handshake covers the sweep
        @(posedge aresetn);
        @(negedge aclk);

        foreach (dir_rows[i])
            send_item(dir_rows[i].stim, idle_len(), dir_rows[i].typed, dir_rows[i].want);

        // Random traffic, mostly live flows with random content
        for (int n = 0; n < RAND_ITEMS; n++) begin
            it.mode        = fclb_pkg::MODE_PACKET;
            it.flow_key    = $urandom;
            it.timestamp   = fclb_pkg::TS_W'({$urandom, $urandom});
            it.entry_index = fclb_pkg::RIDX_W'($urandom);
            if ($urandom_range(0, 19) == 0)
                it.timestamp = $urandom_range(0, 1) ? ts_max : '0;
            have_flow = flow_pool.size() > 0;
            if (have_flow)
                pick = flow_pool[$urandom_range(0, flow_pool.size() - 1)];
            r = $urandom_range(0, 99);
            if (have_flow && r < 30) begin
                // Revisit a known flow: usually a hit
                it.flow_key = pick;
            end else if (have_flow && r < 40) begin
                // Repeat the key of the last packet
                it.flow_key = last_key;
            end else if (have_flow && r < 52) begin
                // Same entry, different upper key bits: evict
                it.flow_key[fclb_pkg::RIDX_W-1:0] = pick[fclb_pkg::RIDX_W-1:0];
                flow_pool.insert(flow_pool.size(), it.flow_key);
            end else if (have_flow && r < 95 && r >= 75) begin
                // Read back an entry that holds a learned flow
                it.mode        = fclb_pkg::MODE_READ;
                it.entry_index = pick[fclb_pkg::RIDX_W-1:0];
            end else begin
                // Fresh random flow
                flow_pool.insert(flow_pool.size(), it.flow_key);
            end
            if (flow_pool.size() > POOL_MAX)
                void'(flow_pool.pop_front());
            if (it.mode == fclb_pkg::MODE_PACKET)
                last_key = it.flow_key;

            // Drain: pause the sender until every result is back
            if (n == RAND_ITEMS / 2) begin
                s_valid <= 1'b0;
                @(negedge aclk);
                while (pending_results.size() != 0) @(negedge aclk);
            end

            // Calm stretch with no sender gaps
            gap = (n >= 120 && n < 200) ? 0 : idle_len();
            send_item(it, gap, 1'b0, '0);
        end
        s_valid <= 1'b0;

        // Wait out the remaining results, then a quiet tail
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (fail_count == 0) begin
            $display("[flow_cache_load_balancer] OK");
        end else begin
            $display("[flow_cache_load_balancer] ERROR");
        end
        $finish;
    end

endmodule

FILE: filelist.f
design/fclb_pkg.sv
design/fclb_table.sv
design/fclb_update.sv
design/flow_cache_load_balancer.sv
test/tb_top.sv
